// File: rtl/buddy_block_allocator_defines.svh
// Assertion macros shared by the allocator checker.
// Needs nothing else; included by files that assert.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bba_pkg.sv
// Types and constants of the buddy block allocator.
// Used by the top level and its checker; depends on nothing.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int FRAME_W = 52;
    localparam int ORDER_W = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W = 10;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_COUNT = 2'd2,
        KIND_INIT  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOT_READY  = 3'd1,
        ST_BAD_ORDER  = 3'd2,
        ST_NO_SPACE   = 3'd3,
        ST_BAD_FRAME  = 3'd4,
        ST_MISALIGNED = 3'd5
    } status_t;

    typedef enum logic {
        CFG_ARENA_BASE = 1'b0,
        CFG_TOP_ORDER  = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SEED,
        S_A_RD,
        S_A_CHK,
        S_SPLIT,
        S_M_RD,
        S_M_CHK,
        S_C_RD,
        S_C_CHK,
        S_DONE
    } state_t;

endpackage

// File: rtl/buddy_block_allocator.sv
// Buddy block allocator: one arena of 2^top_order frames, free bitmap per order.
// Uses bba_pkg. The bitmap lives in a single-port-write, registered-read memory.
//
// Usage: write arena_base_frame (index 0) and top_order (index 1) through the
// cfg port while idle, then send an initialize transaction (kind 3). After it,
// allocate (0), release (1) and count (2) transactions are served. Every input
// transaction gives exactly one result transaction on the m_ channel.
// One item is worked at a time; s_ready is high only when the engine is idle.
// Work per item, all sequenced by the single bitmap memory port:
//   initialize: a clearing sweep over every map bit, then the seed write
//   allocate:   a read and check per bitmap bit scanned, then one split step
//               per level when a block is granted; no space when arena is full
//   release:    a buddy read and check per merge level, up to the top order
//   count:      a read and check per block of that order
//   rejected items: no bitmap access
// After reset the arena is not ready; no clearing is done until initialize.
// A finished result sits in the output register; while the receiver stalls,
// one more item may be accepted and finished, then the engine waits.
`timescale 1ns / 1ps

module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int ORDER_LIMIT = 9
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [FRAME_W-1:0]  cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_kind,
    input  logic [ORDER_W-1:0]  s_block_order,
    input  logic [FRAME_W-1:0]  s_frame_number,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [FRAME_W-1:0]  m_granted_frame,
    output logic [COUNT_W-1:0]  m_free_blocks
);

    localparam int AW = ORDER_LIMIT + 1;
    localparam int DEPTH = (1 << AW) - 1;
    localparam int BW = ORDER_LIMIT;

    // order o begins at 2^(M+1) - 2^(M+1-o)
    function automatic logic [AW-1:0] map_idx(input logic [ORDER_W-1:0] o,
                                              input logic [BW-1:0] b);
        logic [AW:0] first;
        first = ((AW+1)'(1) << AW) - ((AW+1)'(1) << (AW - int'(o)));
        return first[AW-1:0] + AW'(b);
    endfunction

    logic mem [DEPTH];
    logic rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic wr_data;

    state_t state_reg, state_next;
    logic [FRAME_W-1:0] cfg_base_reg, cfg_base_next;
    logic [ORDER_W-1:0] cfg_top_reg, cfg_top_next;
    logic [FRAME_W-1:0] act_base_reg, act_base_next;
    logic [ORDER_W-1:0] act_top_reg, act_top_next;
    logic ready_reg, ready_next;
    logic [ORDER_W-1:0] o_reg, o_next;
    logic [ORDER_W-1:0] req_reg, req_next;
    logic [BW-1:0] b_reg, b_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    status_t res_status_reg, res_status_next;
    logic [FRAME_W-1:0] res_granted_reg, res_granted_next;
    logic m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [FRAME_W-1:0] m_granted_reg, m_granted_next;
    logic [COUNT_W-1:0] m_free_reg, m_free_next;

    kind_t kind;
    logic top_bad, misaligned, order_bad, frame_low, range_bad;
    logic [15:0] align_mask;
    logic [FRAME_W-1:0] diff, diff_sh;
    logic [AW-1:0] last_b;
    logic b_last, top_hit, out_free;

    assign kind       = kind_t'(s_kind);
    assign top_bad    = cfg_top_reg > ORDER_W'(ORDER_LIMIT);
    assign align_mask = (16'd1 << cfg_top_reg) - 16'd1;
    assign misaligned = |(cfg_base_reg[15:0] & align_mask);
    assign order_bad  = s_block_order > act_top_reg;
    assign frame_low  = s_frame_number < act_base_reg;
    assign diff       = s_frame_number - act_base_reg;
    assign diff_sh    = diff >> s_block_order;
    assign range_bad  = frame_low || ((diff >> act_top_reg) != '0);
    assign last_b     = (AW'(1) << (act_top_reg - o_reg)) - AW'(1);
    assign b_last     = {1'b0, b_reg} == last_b;
    assign top_hit    = o_reg == act_top_reg;
    assign out_free   = !m_valid_reg || m_ready;

    assign s_ready         = state_reg == S_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_frame = m_granted_reg;
    assign m_free_blocks   = m_free_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (kind == KIND_INIT) begin
                        state_next = (top_bad || misaligned) ? S_DONE : S_CLEAR;
                    end else if (!ready_reg || order_bad) begin
                        state_next = S_DONE;
                    end else if (kind == KIND_ALLOC) begin
                        state_next = S_A_RD;
                    end else if (kind == KIND_FREE) begin
                        state_next = range_bad ? S_DONE : S_M_RD;
                    end else begin
                        state_next = S_C_RD;
                    end
                end
            end
            S_CLEAR: begin
                if (clr_reg == AW'(DEPTH - 1)) state_next = S_SEED;
            end
            S_SEED:  state_next = S_DONE;
            S_A_RD:  state_next = S_A_CHK;
            S_A_CHK: begin
                if (rd_data_reg) state_next = S_SPLIT;
                else if (b_last && top_hit) state_next = S_DONE;
                else state_next = S_A_RD;
            end
            S_SPLIT: begin
                if (o_reg <= req_reg) state_next = S_DONE;
            end
            S_M_RD:  state_next = (o_reg < act_top_reg) ? S_M_CHK : S_DONE;
            S_M_CHK: state_next = rd_data_reg ? S_M_RD : S_DONE;
            S_C_RD:  state_next = S_C_CHK;
            S_C_CHK: state_next = b_last ? S_DONE : S_C_RD;
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cfg_base_next    = cfg_base_reg;
        cfg_top_next     = cfg_top_reg;
        act_base_next    = act_base_reg;
        act_top_next     = act_top_reg;
        ready_next       = ready_reg;
        o_next           = o_reg;
        req_next         = req_reg;
        b_next           = b_reg;
        clr_next         = clr_reg;
        cnt_next         = cnt_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_granted_next   = m_granted_reg;
        m_free_next      = m_free_reg;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = 1'b0;

        if (cfg_wr_en) begin
            if (cfg_index == CFG_ARENA_BASE) cfg_base_next = cfg_data;
            else cfg_top_next = cfg_data[ORDER_W-1:0];
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_status_next  = ST_OK;
                    res_granted_next = '0;
                    cnt_next         = '0;
                    req_next         = s_block_order;
                    o_next           = s_block_order;
                    b_next           = '0;
                    clr_next         = '0;
                    if (kind == KIND_INIT) begin
                        if (top_bad) begin
                            res_status_next = ST_BAD_ORDER;
                        end else if (misaligned) begin
                            res_status_next = ST_MISALIGNED;
                        end else begin
                            act_base_next = cfg_base_reg;
                            act_top_next  = cfg_top_reg;
                        end
                    end else if (!ready_reg) begin
                        res_status_next = ST_NOT_READY;
                    end else if (order_bad) begin
                        res_status_next = ST_BAD_ORDER;
                    end else if (kind == KIND_FREE) begin
                        if (range_bad) res_status_next = ST_BAD_FRAME;
                        else b_next = diff_sh[BW-1:0];
                    end
                end
            end
            S_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + AW'(1);
            end
            S_SEED: begin
                wr_en      = 1'b1;
                wr_addr    = map_idx(act_top_reg, '0);
                wr_data    = 1'b1;
                ready_next = 1'b1;
            end
            S_A_RD: rd_addr = map_idx(o_reg, b_reg);
            S_A_CHK: begin
                if (rd_data_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = map_idx(o_reg, b_reg);
                end else if (b_last) begin
                    if (top_hit) begin
                        res_status_next = ST_NO_SPACE;
                    end else begin
                        o_next = o_reg + ORDER_W'(1);
                        b_next = '0;
                    end
                end else begin
                    b_next = b_reg + BW'(1);
                end
            end
            S_SPLIT: begin
                if (o_reg > req_reg) begin
                    // free the right half one order down
                    wr_en   = 1'b1;
                    wr_addr = map_idx(o_reg - ORDER_W'(1), (b_reg << 1) | BW'(1));
                    wr_data = 1'b1;
                    o_next  = o_reg - ORDER_W'(1);
                    b_next  = b_reg << 1;
                end else begin
                    res_granted_next = act_base_reg + (FRAME_W'(b_reg) << req_reg);
                end
            end
            S_M_RD: begin
                if (o_reg < act_top_reg) begin
                    rd_addr = map_idx(o_reg, b_reg ^ BW'(1));
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = map_idx(o_reg, b_reg);
                    wr_data = 1'b1;
                end
            end
            S_M_CHK: begin
                wr_en = 1'b1;
                if (rd_data_reg) begin
                    // buddy free: take it and climb
                    wr_addr = map_idx(o_reg, b_reg ^ BW'(1));
                    b_next  = b_reg >> 1;
                    o_next  = o_reg + ORDER_W'(1);
                end else begin
                    wr_addr = map_idx(o_reg, b_reg);
                    wr_data = 1'b1;
                end
            end
            S_C_RD: rd_addr = map_idx(req_reg, b_reg);
            S_C_CHK: begin
                cnt_next = cnt_reg + COUNT_W'(rd_data_reg);
                if (!b_last) b_next = b_reg + BW'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_granted_next = res_granted_reg;
                    m_free_next    = cnt_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cfg_base_reg <= '0;
            cfg_top_reg  <= '0;
            act_base_reg <= '0;
            act_top_reg  <= '0;
            ready_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cfg_base_reg <= cfg_base_next;
            cfg_top_reg  <= cfg_top_next;
            act_base_reg <= act_base_next;
            act_top_reg  <= act_top_next;
            ready_reg    <= ready_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        o_reg           <= o_next;
        req_reg         <= req_next;
        b_reg           <= b_next;
        clr_reg         <= clr_next;
        cnt_reg         <= cnt_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        m_status_reg    <= m_status_next;
        m_granted_reg   <= m_granted_next;
        m_free_reg      <= m_free_next;
    end

endmodule

// File: rtl/bba_checker.sv
// Port-level checks on the allocator result channel, bound to the top level.
// Uses bba_pkg and buddy_block_allocator_defines.svh.
`timescale 1ns / 1ps
`include "buddy_block_allocator_defines.svh"

module bba_checker
    import bba_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [FRAME_W-1:0]  m_granted_frame,
    input logic [COUNT_W-1:0]  m_free_blocks
);

    `BBA_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_granted_frame), "result changed while stalled")
    `BBA_ASSERT_SAME(a_grant_ok, aclk, aresetn, m_valid && (m_status != ST_OK), m_granted_frame == '0, "frame granted on failed transaction")
    `BBA_ASSERT_SAME(a_count_ok, aclk, aresetn, m_valid && (m_status != ST_OK), m_free_blocks == '0, "count reported on failed transaction")
    `BBA_ASSERT_SAME(a_one_field, aclk, aresetn, m_valid && (m_granted_frame != '0), m_free_blocks == '0, "grant and count in one result")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
